// ----- hdl/ulp_pkg.sv -----
// ----------------------------------------------------------------------------
// ulp_pkg: shared types and constants for the integer literal parser
// Phase and status codes, character codes and the digit decoder.
// ----------------------------------------------------------------------------
package ulp_pkg;

    // Parse phase, one per item of the literal
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEAD0  = 3'd1,
        PH_DEC    = 3'd2,
        PH_HEX    = 3'd3,
        PH_OCT    = 3'd4,
        PH_DONE   = 3'd5,
        PH_NOTINT = 3'd6
    } t_phase;

    // Status code reported with each result
    typedef enum logic [1:0] {
        ST_BUSY   = 2'd0,
        ST_DONE   = 2'd1,
        ST_NOTINT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RADIX_OCT = 2'd0,
        RADIX_DEC = 2'd1,
        RADIX_HEX = 2'd2
    } t_radix;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_X  = 8'h78;

    // Decode one character as a digit of the given radix
    function automatic t_digit digit_of(input logic [7:0] c, input t_radix r);
        t_digit d;
        d.ok  = 1'b0;
        d.val = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.val = c[3:0];
            d.ok  = (r != RADIX_OCT) || (c <= CH_SEVEN);
        end else if (r == RADIX_HEX &&
                     ((c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F))) begin
            d.ok  = 1'b1;
            d.val = 4'(c[2:0]) + 4'd9;
        end
        return d;
    endfunction

    function automatic t_status status_of(input t_phase p);
        t_status s;
        case (p)
            PH_NOTINT: s = ST_NOTINT;
            PH_DONE:   s = ST_DONE;
            default:   s = ST_BUSY;
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/uint128_literal_parser.sv -----
// ----------------------------------------------------------------------------
// uint128_literal_parser: streaming C integer literal parser
// Takes one character per transaction and returns the running value and
// parse status (decimal, 0x hexadecimal, leading-zero octal).
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------
//  input   | in        | i_in_valid / o_in_ready | i_char_code, i_first_char
//  output  | out       | o_out_valid/ i_out_ready| o_value_high, o_value_low,
//          |           |                         | o_parse_status
//
//  One transaction can enter every cycle while the output side is not stalled.
//  The result is registered: the single adder that forms acc * radix + digit
//  (a three-input add over VALUE_WIDTH bits) feeds the phase and accumulator registers.
//  The phase and accumulator registers are also the result register.
//  Reset (synchronous, active low) returns to idle with a zero value.
//  A stalled result holds; input is taken in the same cycle the result
//  leaves, so a stall on the output side stalls the input side.
// ----------------------------------------------------------------------------
module uint128_literal_parser #(
    parameter int VALUE_WIDTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_first_char,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_value_high,
    output logic [63:0] o_value_low,
    output logic [1:0]  o_parse_status
);

    localparam int OUT_WIDTH = 128;

    ulp_pkg::t_phase        r_phase, n_phase;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic                   r_out_valid;

    logic                   w_in_accept;
    ulp_pkg::t_radix        w_radix;
    ulp_pkg::t_digit        w_digit;
    logic [VALUE_WIDTH-1:0] w_base;
    logic [VALUE_WIDTH-1:0] w_term_a;
    logic [VALUE_WIDTH-1:0] w_term_b;
    logic [VALUE_WIDTH-1:0] w_mac;
    logic [OUT_WIDTH-1:0]   w_ext;

    // Accept when the result slot is empty or is being drained this cycle
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_accept = i_in_valid && o_in_ready;

    // Pick the radix for the digit decoder from the current phase; a first character is decimal
    always_comb begin
        if (i_first_char) begin
            w_radix = ulp_pkg::RADIX_DEC;
        end else begin
            case (r_phase)
                ulp_pkg::PH_HEX:   w_radix = ulp_pkg::RADIX_HEX;
                ulp_pkg::PH_DEC:   w_radix = ulp_pkg::RADIX_DEC;
                default:           w_radix = ulp_pkg::RADIX_OCT;
            endcase
        end
    end

    assign w_digit = ulp_pkg::digit_of(i_char_code, w_radix);

    // acc * radix + digit as shifts and one three-input add.
    // A new literal starts from zero, whatever the register holds.
    assign w_base = i_first_char ? '0 : r_acc;

    always_comb begin
        case (w_radix)
            ulp_pkg::RADIX_HEX: begin
                w_term_a = w_base << 4;
                w_term_b = '0;
            end
            ulp_pkg::RADIX_DEC: begin
                w_term_a = w_base << 3;
                w_term_b = w_base << 1;
            end
            default: begin
                w_term_a = w_base << 3;
                w_term_b = '0;
            end
        endcase
    end

    assign w_mac = w_term_a + w_term_b + VALUE_WIDTH'(w_digit.val);

    // Next phase and accumulator
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        if (i_first_char) begin
            n_acc = '0;
            if (!w_digit.ok) begin
                n_phase = ulp_pkg::PH_NOTINT;
            end else if (i_char_code == ulp_pkg::CH_ZERO) begin
                n_phase = ulp_pkg::PH_LEAD0;
            end else begin
                n_phase = ulp_pkg::PH_DEC;
                n_acc   = w_mac;
            end
        end else begin
            case (r_phase)
                ulp_pkg::PH_LEAD0: begin
                    // 0x opens hex; an octal digit is the first octal character, anything else ends the literal
                    if (i_char_code == ulp_pkg::CH_LC_X) begin
                        n_phase = ulp_pkg::PH_HEX;
                    end else if (w_digit.ok) begin
                        n_phase = ulp_pkg::PH_OCT;
                        n_acc   = w_mac;
                    end else begin
                        n_phase = ulp_pkg::PH_DONE;
                    end
                end
                ulp_pkg::PH_DEC, ulp_pkg::PH_HEX, ulp_pkg::PH_OCT: begin
                    if (w_digit.ok) begin
                        n_acc = w_mac;
                    end else begin
                        n_phase = ulp_pkg::PH_DONE;
                    end
                end
                default: begin
                    // idle, done and not-an-integer ignore the character
                end
            endcase
        end
    end

    // State doubles as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ulp_pkg::PH_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
            end
            if (w_in_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Zero-extend to the full output width; bits above VALUE_WIDTH read 0
    assign w_ext          = OUT_WIDTH'(r_acc);
    assign o_value_high   = w_ext[127:64];
    assign o_value_low    = w_ext[63:0];
    assign o_parse_status = ulp_pkg::status_of(r_phase);
    assign o_out_valid    = r_out_valid;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Hold the accumulator unless a transaction is accepted
    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_accept |=> $stable(r_acc))
        else $error("accumulator changed without an input transaction");

    // A start on a non-digit reports not-an-integer with a zero value
    a_notint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_first_char &&
         (i_char_code < ulp_pkg::CH_ZERO || i_char_code > ulp_pkg::CH_NINE))
        |=> (o_parse_status == ulp_pkg::ST_NOTINT && r_acc == '0))
        else $error("non-digit start did not report not-an-integer");

    // Once done, a continuing character leaves value and status alone
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && !i_first_char && r_phase == ulp_pkg::PH_DONE)
        |=> (r_phase == ulp_pkg::PH_DONE && $stable(r_acc)))
        else $error("done literal changed before the next start");

endmodule

// ----- test/ulp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulp_checker: result predictor and comparator for the literal parser
// Watches both channels. Each accepted character advances a private copy of
// the parse state, and the resulting value and status are queued. Each
// accepted result is compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module ulp_checker import ulp_pkg::*; #(
    parameter int VALUE_WIDTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_first_char,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_value_high,
    input  logic [63:0] i_value_low,
    input  logic [1:0]  i_parse_status,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [127:0] ACC_MASK = {128{1'b1}} >> (128 - VALUE_WIDTH);

    typedef struct {
        logic [63:0] value_high;
        logic [63:0] value_low;
        t_status     status;
    } t_parse_result;

    t_parse_result parse_results_q[$];

    t_phase       lit_phase;
    logic [127:0] lit_value;
    int           mismatches;

    function automatic int radix_base(input t_radix r);
        case (r)
            RADIX_OCT: return 8;
            RADIX_DEC: return 10;
            default:   return 16;
        endcase
    endfunction

    // -1 when the character is not a digit of the radix
    function automatic int char_digit(input logic [7:0] c, input t_radix r);
        int d;
        d = -1;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = int'(c) - int'(CH_ZERO);
        end else if (r == RADIX_HEX && c >= CH_LC_A && c <= CH_LC_F) begin
            d = int'(c) - int'(CH_LC_A) + 10;
        end else if (r == RADIX_HEX && c >= CH_UC_A && c <= CH_UC_F) begin
            d = int'(c) - int'(CH_UC_A) + 10;
        end
        if (d >= radix_base(r)) begin
            d = -1;
        end
        return d;
    endfunction

    task automatic take_digit(input logic [7:0] c, input t_radix r);
        int d;
        d = char_digit(c, r);
        if (d < 0) begin
            lit_phase = PH_DONE;
        end else begin
            lit_value = (lit_value * 128'(radix_base(r)) + 128'(d)) & ACC_MASK;
        end
    endtask

    task automatic advance_literal(input logic [7:0] c, input logic first);
        if (first) begin
            lit_value = '0;
            if (char_digit(c, RADIX_DEC) < 0) begin
                lit_phase = PH_NOTINT;
            end else if (c == CH_ZERO) begin
                lit_phase = PH_LEAD0;
            end else begin
                lit_phase = PH_DEC;
                take_digit(c, RADIX_DEC);
            end
        end else begin
            case (lit_phase)
                PH_LEAD0: begin
                    if (c == CH_LC_X) begin
                        lit_phase = PH_HEX;
                    end else begin
                        lit_phase = PH_OCT;
                        take_digit(c, RADIX_OCT);
                    end
                end
                PH_DEC:  take_digit(c, RADIX_DEC);
                PH_HEX:  take_digit(c, RADIX_HEX);
                PH_OCT:  take_digit(c, RADIX_OCT);
                default: ;
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        t_parse_result want;
        t_parse_result pred;
        if (!i_rst_n) begin
            lit_phase = PH_IDLE;
            lit_value = '0;
            mismatches = 0;
            parse_results_q.delete();
        end else begin
            // Retire the outgoing result first: the result is registered, so it
            // never belongs to a character taken at this same edge.
            if (i_out_valid && i_out_ready) begin
                if (parse_results_q.size() == 0) begin
                    $error("result with nothing expected: value %h_%h status %0d",
                           i_value_high, i_value_low, i_parse_status);
                    mismatches++;
                end else begin
                    want = parse_results_q.pop_front();
                    if (i_value_high !== want.value_high) begin
                        $error("value_high: expected %h, actual %h",
                               want.value_high, i_value_high);
                        mismatches++;
                    end
                    if (i_value_low !== want.value_low) begin
                        $error("value_low: expected %h, actual %h",
                               want.value_low, i_value_low);
                        mismatches++;
                    end
                    if (i_parse_status !== want.status) begin
                        $error("parse_status: expected %0d, actual %0d",
                               want.status, i_parse_status);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                advance_literal(i_char_code, i_first_char);
                pred.value_high = lit_value[127:64];
                pred.value_low  = lit_value[63:0];
                case (lit_phase)
                    PH_NOTINT: pred.status = ST_NOTINT;
                    PH_DONE:   pred.status = ST_DONE;
                    default:   pred.status = ST_BUSY;
                endcase
                parse_results_q.push_back(pred);
            end
        end
        o_pending    <= parse_results_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the integer literal parser
// Drives directed literals that hit each special case, then random
// decimal, hexadecimal, octal and malformed literals with random idle gaps
// on both sides. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import ulp_pkg::*;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam int         ROUNDS    = 6;
    localparam int         ROUND_LEN = 185;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_char_code;
    logic        i_first_char;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_value_high;
    logic [63:0] o_value_low;
    logic [1:0]  o_parse_status;

    int fail_count;
    int pending;

    // Idle controls: when set, that side never idles
    bit quiet_src;
    bit quiet_sink;
    int sink_hold;
    int literal_chars;

    uint128_literal_parser i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .i_first_char   (i_first_char),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_value_high   (o_value_high),
        .o_value_low    (o_value_low),
        .o_parse_status (o_parse_status)
    );

    ulp_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .i_first_char   (i_first_char),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_value_high   (o_value_high),
        .i_value_low    (o_value_low),
        .i_parse_status (o_parse_status),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Receiver side: stall at random, hold ready low for the whole stall
    always @(posedge i_clk) begin
        int stall_len;
        if (!i_rst_n) begin
            sink_hold   <= 0;
            i_out_ready <= 1'b0;
        end else if (sink_hold != 0) begin
            sink_hold   <= sink_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            stall_len = (quiet_sink || $urandom_range(0, 3) != 0) ? 0 : idle_len();
            if (stall_len != 0) begin
                sink_hold   <= stall_len - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Present one character and hold it until the transaction completes.
    // Called at a clock edge; returns at the edge that accepts it.
    task automatic send_char(input logic [7:0] c, input logic first);
        int gap;
        gap = quiet_src ? 0 : idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_char_code  <= c;
        i_first_char <= first;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    // Drop valid and hold off until every queued result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [7:0] non_digit_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c >= CH_ZERO && c <= CH_NINE);
        return c;
    endfunction

    function automatic logic [7:0] hex_digit_char();
        int d;
        d = $urandom_range(0, 15);
        if (d < 10) begin
            return CH_ZERO + 8'(d);
        end
        return ($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + 8'(d - 10);
    endfunction

    // One literal: leading characters, random digits, a terminator, and a
    // few trailing characters that the block should ignore.
    task automatic random_literal();
        int         kind;
        int         len;
        int         r;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        // Mostly short literals; a few long enough to wrap 128 bits
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 10);
        if (kind < 30) begin
            send_char(CH_ZERO + 8'($urandom_range(1, 9)), 1'b1);
            repeat (len - 1) send_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            literal_chars += len;
        end else if (kind < 55) begin
            send_char(CH_ZERO, 1'b1);
            send_char(CH_LC_X, 1'b0);
            repeat (len) send_char(hex_digit_char(), 1'b0);
            literal_chars += len + 2;
        end else if (kind < 75) begin
            send_char(CH_ZERO, 1'b1);
            repeat (len) send_char(CH_ZERO + 8'($urandom_range(0, 7)), 1'b0);
            literal_chars += len + 1;
        end else if (kind < 82) begin
            send_char(CH_ZERO, 1'b1);
            literal_chars += 1;
        end else if (kind < 90) begin
            send_char(non_digit_byte(), 1'b1);
            literal_chars += 1;
        end else begin
            // Noise: any byte, either start flag
            send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            literal_chars += 1;
        end
        r = $urandom_range(0, 9);
        if (r < 4) begin
            c = CH_NUL;
        end else if (r < 8) begin
            c = non_digit_byte();
        end else begin
            c = 8'($urandom_range(0, 255));
        end
        send_char(c, 1'b0);
        literal_chars += 1;
        r = $urandom_range(0, 2);
        repeat (r) send_char(8'($urandom_range(0, 255)), 1'b0);
        literal_chars += r;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_char_code   = CH_NUL;
        i_first_char  = 1'b0;
        quiet_src     = 1'b0;
        quiet_sink    = 1'b0;
        literal_chars = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Idle before any start: characters without the start flag are ignored
        send_char("7", 1'b0);
        send_char(CH_NUL, 1'b0);
        // Lone zero ended by the terminator, then a character after done
        send_char("0", 1'b1);
        send_char(CH_NUL, 1'b0);
        send_char("x", 1'b0);
        // Empty hexadecimal
        send_char("0", 1'b1);
        send_char("x", 1'b0);
        send_char("g", 1'b0);
        // Hexadecimal with both letter cases
        send_char("0", 1'b1);
        send_char("x", 1'b0);
        send_char("a", 1'b0);
        send_char("F", 1'b0);
        send_char("9", 1'b0);
        send_char("A", 1'b0);
        send_char("f", 1'b0);
        send_char(CH_NUL, 1'b0);
        // Octal ended by a digit that is not octal
        send_char("0", 1'b1);
        send_char("1", 1'b0);
        send_char("7", 1'b0);
        send_char("8", 1'b0);
        // Decimal ended by a byte above 127
        send_char("9", 1'b1);
        send_char(8'hFF, 1'b0);
        // Uppercase X after zero is not a hex prefix
        send_char("0", 1'b1);
        send_char("X", 1'b0);
        // Not an integer, held through a later digit, then two more non-digit starts
        send_char("a", 1'b1);
        send_char("1", 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(CH_NUL, 1'b1);
        // Lone zero before a decimal digit that is not octal
        send_char("0", 1'b1);
        send_char("9", 1'b0);
        drain_results();

        // Random rounds; drain between rounds so the sender pauses with
        // nothing outstanding. Round 1 never idles the sender, round 2 never
        // stalls the receiver.
        for (int rnd = 0; rnd < ROUNDS; rnd++) begin
            quiet_src  = (rnd == 1);
            quiet_sink = (rnd == 2);
            while (literal_chars < (rnd + 1) * ROUND_LEN) begin
                random_literal();
            end
            drain_results();
        end
        quiet_sink = 1'b0;

        // Allow the registered result to settle before the verdict
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: well above the slowest legal run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
